// File: hdl/rntl_pkg.sv
// Shared types, constants and character classifiers for the Roman numeral token lexer.
package rntl_pkg;

   // Offset, line and field widths and derived limits
   localparam int POS_WIDTH = 32;
   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
   localparam int LINE_WIDTH = 32;
   localparam logic [LINE_WIDTH-1:0] LINE_MAX = {LINE_WIDTH{1'b1}};
   localparam int OFS_WIDTH = 32;
   localparam int VAL_WIDTH = 64;
   localparam int DIGIT_WIDTH = 7;

   // Result queue geometry
   localparam int QDEPTH = 4;
   localparam int QPTR_WIDTH = $clog2(QDEPTH);
   localparam int QCNT_WIDTH = $clog2(QDEPTH + 1);

   // Token type codes
   localparam logic [2:0] TOK_SEMI        = 3'd0;
   localparam logic [2:0] TOK_LPAREN      = 3'd1;
   localparam logic [2:0] TOK_RPAREN      = 3'd2;
   localparam logic [2:0] TOK_OPEN_BRACE  = 3'd3;
   localparam logic [2:0] TOK_CLOSE_BRACE = 3'd4;
   localparam logic [2:0] TOK_NUMBER      = 3'd5;
   localparam logic [2:0] TOK_IDENT       = 3'd6;
   localparam logic [2:0] TOK_END         = 3'd7;

   // Scanner modes
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_NUM   = 2'd1;
   localparam logic [1:0] MODE_IDENT = 2'd2;

   // Input kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Characters of interest
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_I       = 8'h49;
   localparam logic [7:0] CH_V       = 8'h56;
   localparam logic [7:0] CH_X       = 8'h58;
   localparam logic [7:0] CH_L       = 8'h4C;
   localparam logic [7:0] CH_C       = 8'h43;

   // One emitted token
   typedef struct packed {
      logic [2:0]           tok_type;
      logic [OFS_WIDTH-1:0] start_pos;
      logic [OFS_WIDTH-1:0] token_len;
      logic [OFS_WIDTH-1:0] line_number;
      logic [OFS_WIDTH-1:0] line_begin;
      logic [VAL_WIDTH-1:0] number_value;
      logic                 last;
   } rntl_token_type;

   // Tokens produced by one transfer, in order
   typedef struct packed {
      logic [1:0]     count;
      rntl_token_type tok0;
      rntl_token_type tok1;
   } rntl_push_type;

   function automatic logic is_space(input logic [7:0] c);
      return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
   endfunction

   // Bit 3 flags punctuation, low bits give the token type
   function automatic logic [3:0] punct_code(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         CH_SEMI:   r = {1'b1, TOK_SEMI};
         CH_LPAREN: r = {1'b1, TOK_LPAREN};
         CH_RPAREN: r = {1'b1, TOK_RPAREN};
         CH_LBRACE: r = {1'b1, TOK_OPEN_BRACE};
         CH_RBRACE: r = {1'b1, TOK_CLOSE_BRACE};
         default:   r = 4'd0;
      endcase
      return r;
   endfunction

   // Zero means not a Roman digit
   function automatic logic [DIGIT_WIDTH-1:0] roman_weight(input logic [7:0] c);
      logic [DIGIT_WIDTH-1:0] w;
      case (c)
         CH_I:    w = DIGIT_WIDTH'(1);
         CH_V:    w = DIGIT_WIDTH'(5);
         CH_X:    w = DIGIT_WIDTH'(10);
         CH_L:    w = DIGIT_WIDTH'(50);
         CH_C:    w = DIGIT_WIDTH'(100);
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// File: hdl/rntl_req_if.sv
// Input channel: source bytes and end-of-input markers.
interface rntl_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_byte;

   modport source (output valid, output kind, output char_byte, input ready);
   modport sink (input valid, input kind, input char_byte, output ready);
endinterface

// File: hdl/rntl_rsp_if.sv
// Result channel: one token per transfer.
interface rntl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_type;
   logic [31:0] start_pos;
   logic [31:0] token_len;
   logic [31:0] line_number;
   logic [31:0] line_begin;
   logic [63:0] number_value;
   logic        last;

   modport source (output valid, output token_type, output start_pos, output token_len,
                   output line_number, output line_begin, output number_value,
                   output last, input ready);
   modport sink (input valid, input token_type, input start_pos, input token_len,
                 input line_number, input line_begin, input number_value,
                 input last, output ready);
endinterface

// File: hdl/rntl_core.sv
// Lexer state registers and the single-pass token decision for one byte.
module rntl_core
   import rntl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic          kind,
   input  logic [7:0]    char_byte,
   output rntl_push_type push
);

   logic [1:0]             mode_ff, mode_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [LINE_WIDTH-1:0]  line_ff, line_in;
   logic [POS_WIDTH-1:0]   lstart_ff, lstart_in;
   logic [POS_WIDTH-1:0]   tstart_ff, tstart_in;
   logic [VAL_WIDTH-1:0]   total_ff, total_in;
   logic [VAL_WIDTH-1:0]   gsum_ff, gsum_in;
   logic [DIGIT_WIDTH-1:0] gdigit_ff, gdigit_in;

   logic                   sp;
   logic [3:0]             pc;
   logic [DIGIT_WIDTH-1:0] w;
   logic [POS_WIDTH-1:0]   pos_inc;
   logic                   flush;
   logic                   second;
   logic                   cont;
   rntl_token_type         flush_tok;
   rntl_token_type         second_tok;

   assign sp      = is_space(char_byte);
   assign pc      = punct_code(char_byte);
   assign w       = roman_weight(char_byte);
   assign pos_inc = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;

   // Pending number or identifier closed by this transfer
   always_comb begin
      flush_tok              = '0;
      flush_tok.tok_type     = (mode_ff == MODE_NUM) ? TOK_NUMBER : TOK_IDENT;
      flush_tok.start_pos    = OFS_WIDTH'(tstart_ff);
      flush_tok.token_len    = OFS_WIDTH'(pos_ff - tstart_ff);
      flush_tok.line_number  = OFS_WIDTH'(line_ff);
      flush_tok.line_begin   = OFS_WIDTH'(lstart_ff);
      flush_tok.number_value = (mode_ff == MODE_NUM) ? total_ff + gsum_ff : '0;
   end

   // Next state and the token raised by the byte itself
   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      line_in    = line_ff;
      lstart_in  = lstart_ff;
      tstart_in  = tstart_ff;
      total_in   = total_ff;
      gsum_in    = gsum_ff;
      gdigit_in  = gdigit_ff;
      flush      = 1'b0;
      second     = 1'b0;
      cont       = 1'b0;
      second_tok = '0;
      second_tok.line_number = OFS_WIDTH'(line_ff);
      second_tok.line_begin  = OFS_WIDTH'(lstart_ff);
      second_tok.start_pos   = OFS_WIDTH'(pos_ff);
      if (accept) begin
         if (kind == KIND_END) begin
            flush               = (mode_ff != MODE_IDLE);
            second              = 1'b1;
            second_tok.tok_type = TOK_END;
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            line_in   = LINE_WIDTH'(1);
            lstart_in = POS_WIDTH'(1);
            tstart_in = '0;
            total_in  = '0;
            gsum_in   = '0;
            gdigit_in = '0;
         end else begin
            pos_in = pos_inc;
            // Continue a number or identifier
            if (mode_ff == MODE_NUM && w != '0) begin
               cont = 1'b1;
               if (gdigit_ff != '0 && gdigit_ff != w) begin
                  total_in = (gdigit_ff < w) ? total_ff - gsum_ff : total_ff + gsum_ff;
                  gsum_in  = VAL_WIDTH'(w);
               end else begin
                  gsum_in = gsum_ff + VAL_WIDTH'(w);
               end
               gdigit_in = w;
            end else if (mode_ff == MODE_IDENT && !sp && !pc[3]) begin
               cont = 1'b1;
            end else if (mode_ff != MODE_IDLE) begin
               flush   = 1'b1;
               mode_in = MODE_IDLE;
            end
            // Byte handled on its own
            if (!cont) begin
               if (sp) begin
                  if (char_byte == CH_NEWLINE) begin
                     line_in   = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
                     lstart_in = pos_ff;
                  end
               end else if (pc[3]) begin
                  second              = 1'b1;
                  second_tok.tok_type = pc[2:0];
                  second_tok.token_len = OFS_WIDTH'(1);
               end else if (char_byte == CH_ZERO) begin
                  tstart_in = pos_ff;
                  total_in  = '0;
                  gsum_in   = '0;
                  gdigit_in = '0;
                  mode_in   = MODE_NUM;
               end else begin
                  tstart_in = pos_ff;
                  mode_in   = MODE_IDENT;
               end
            end
         end
      end
   end

   // Pack tokens in order, marking the final one
   always_comb begin
      push = '0;
      if (flush) begin
         push.tok0      = flush_tok;
         push.tok0.last = !second;
         push.tok1      = second_tok;
         push.tok1.last = 1'b1;
         push.count     = second ? 2'd2 : 2'd1;
      end else if (second) begin
         push.tok0      = second_tok;
         push.tok0.last = 1'b1;
         push.count     = 2'd1;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         line_ff   <= LINE_WIDTH'(1);
         lstart_ff <= POS_WIDTH'(1);
         tstart_ff <= '0;
         total_ff  <= '0;
         gsum_ff   <= '0;
         gdigit_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         lstart_ff <= lstart_in;
         tstart_ff <= tstart_in;
         total_ff  <= total_in;
         gsum_ff   <= gsum_in;
         gdigit_ff <= gdigit_in;
      end
   end

`ifndef SYNTHESIS
   // End of input restarts the stream
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == KIND_END) |=> (mode_ff == MODE_IDLE && pos_ff == '0))
      else $error("lexer state not restarted after end of input");

   // In a two-token transfer only the second token is marked last
   a_tok_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.tok1.last && !push.tok0.last))
      else $error("two-token transfer marked wrongly");

   // A byte transfer always moves the position unless saturated
   a_pos_moves: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == KIND_BYTE && pos_ff != POS_MAX) |=> (pos_ff == $past(pos_ff) + 1'b1))
      else $error("position did not advance on a byte");
`endif

endmodule

// File: hdl/rntl_fifo.sv
// Result queue: takes up to two tokens per cycle, hands out one per transfer.
module rntl_fifo
   import rntl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rntl_push_type  push,
   output logic           space_ok,
   output logic           out_valid,
   input  logic           out_ready,
   output rntl_token_type out_tok
);

   rntl_token_type         mem_ff [QDEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ff, wr_in;
   logic [QPTR_WIDTH-1:0]  rd_ff, rd_in;
   logic [QCNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                   pop;
   logic [QPTR_WIDTH-1:0]  wr_next;

   assign space_ok  = (cnt_ff <= QCNT_WIDTH'(QDEPTH - 2));
   assign out_valid = (cnt_ff != '0);
   assign out_tok   = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ff + 1'b1;

   // Pointer and occupancy update
   always_comb begin
      wr_in  = wr_ff + QPTR_WIDTH'(push.count);
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_WIDTH'(push.count) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Token storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.tok1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (QDEPTH - cnt_ff >= push.count))
      else $error("result queue overflow");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_WIDTH'(QDEPTH))
      else $error("result queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != QCNT_WIDTH'(QDEPTH)) |-> (QPTR_WIDTH'(wr_ff - rd_ff) == QPTR_WIDTH'(cnt_ff)))
      else $error("result queue pointers disagree with count");
`endif

endmodule

// File: hdl/roman_numeral_token_lexer.sv
// Roman numeral token lexer: streams source bytes in, tokens out.
//
// req_bus carries one source byte per transfer (kind 0) or an end-of-input
// marker (kind 1, byte ignored). rsp_bus carries one token per transfer:
// type, start offset, length, line number, last-newline offset and the value
// of a Roman number literal; last marks the final token raised by an input.
// An input raises zero, one or two tokens. A number or identifier is sent
// when the byte that ends it arrives, so it appears one input later.
// Tokens enter the registered token queue and are offered from its head.
// Throughput: one input per cycle while ready is high; ready drops only when
// the four-entry token queue has fewer than two free slots, and it hands out
// one token per transfer. If the receiver stalls, tokens stay queued and the
// input side stops once the queue nears full.
// Reset (synchronous, active high) restarts the stream: offset 0, line 1,
// line start 1, queue empty. End of input flushes any pending token, sends
// an end token and returns the lexer to the same starting state.
module roman_numeral_token_lexer
   import rntl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   rntl_req_if.sink   req_bus,
   rntl_rsp_if.source rsp_bus
);

   logic           accept;
   logic           space_ok;
   rntl_push_type  push;
   rntl_token_type out_tok;

   assign req_bus.ready = space_ok;
   assign accept        = req_bus.valid && space_ok;

   rntl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_bus.kind),
      .char_byte (req_bus.char_byte),
      .push      (push)
   );

   rntl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_tok   (out_tok)
   );

   // Token fields onto the result channel
   assign rsp_bus.token_type   = out_tok.tok_type;
   assign rsp_bus.start_pos    = out_tok.start_pos;
   assign rsp_bus.token_len    = out_tok.token_len;
   assign rsp_bus.line_number  = out_tok.line_number;
   assign rsp_bus.line_begin   = out_tok.line_begin;
   assign rsp_bus.number_value = out_tok.number_value;
   assign rsp_bus.last         = out_tok.last;

endmodule
